>>> hw/rtl/bdhd_pkg.sv
// Shared types, constants and helpers for the button debounce and hold detector.
package bdhd_pkg;

  localparam int LANES_MAX       = 8;
  localparam int NUM_BUTTONS_DEF = 8;
  localparam int CODE_W          = 3;
  localparam int TIME_W          = 32;
  localparam int THRESH_W        = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 2'd1;

  localparam logic [THRESH_W-1:0] DEBOUNCE_MS_RST = 16'd50;
  localparam logic [THRESH_W-1:0] HOLD_MS_RST     = 16'd1000;

  localparam logic [CODE_W-1:0] CODE_UP       = 3'd0;
  localparam logic [CODE_W-1:0] CODE_PRESSED  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_DEBOUNCE = 3'd2;
  localparam logic [CODE_W-1:0] CODE_DOWN     = 3'd3;
  localparam logic [CODE_W-1:0] CODE_HELD     = 3'd4;
  localparam logic [CODE_W-1:0] CODE_RELEASED = 3'd5;

  typedef enum logic [5:0] {
    ST_UP       = 6'b000001,
    ST_PRESSED  = 6'b000010,
    ST_DEBOUNCE = 6'b000100,
    ST_DOWN     = 6'b001000,
    ST_HELD     = 6'b010000,
    ST_RELEASED = 6'b100000
  } bdhd_state_t;

  typedef struct packed {
    logic [LANES_MAX-1:0] pin_levels;
    logic [TIME_W-1:0]    now_ms;
  } bdhd_in_t;

  typedef struct packed {
    logic [LANES_MAX*CODE_W-1:0] button_states;
    logic [LANES_MAX-1:0]        released_pulses;
  } bdhd_out_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              released;
  } bdhd_lane_t;

  function automatic logic [CODE_W-1:0] state_code(input bdhd_state_t st);
    logic [CODE_W-1:0] c;
    unique case (st)
      ST_UP:       c = CODE_UP;
      ST_PRESSED:  c = CODE_PRESSED;
      ST_DEBOUNCE: c = CODE_DEBOUNCE;
      ST_DOWN:     c = CODE_DOWN;
      ST_HELD:     c = CODE_HELD;
      ST_RELEASED: c = CODE_RELEASED;
      default:     c = CODE_UP;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/bdhd_if.sv
// Valid/ready stream interfaces for the poll and result channels.
interface bdhd_in_if import bdhd_pkg::*; ();
  logic     valid;
  logic     ready;
  bdhd_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bdhd_out_if import bdhd_pkg::*; ();
  logic      valid;
  logic      ready;
  bdhd_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/bdhd_lane.sv
// Per-button debounce and hold state machine with its press timestamp.
module bdhd_lane import bdhd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                pressed,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic [THRESH_W-1:0] debounce_ms,
  input  logic [THRESH_W-1:0] hold_ms,
  output bdhd_lane_t          status
);

  bdhd_state_t       state_r, state_nxt;
  logic [TIME_W-1:0] press_time_r, press_time_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              deb_done, hold_done;

  assign elapsed   = now_ms - press_time_r;
  assign deb_done  = elapsed > {{(TIME_W-THRESH_W){1'b0}}, debounce_ms};
  assign hold_done = elapsed > {{(TIME_W-THRESH_W){1'b0}}, hold_ms};

  always_comb begin
    state_nxt      = state_r;
    press_time_nxt = press_time_r;
    unique case (state_r)
      ST_UP: begin
        if (pressed) begin
          press_time_nxt = now_ms;
          state_nxt      = ST_PRESSED;
        end
      end
      ST_PRESSED: state_nxt = ST_DEBOUNCE;
      ST_DEBOUNCE: begin
        if (deb_done) begin
          if (pressed) begin
            press_time_nxt = now_ms;
            state_nxt      = ST_DOWN;
          end else begin
            state_nxt = ST_UP;
          end
        end
      end
      ST_DOWN: begin
        if (!pressed) begin
          state_nxt = ST_RELEASED;
        end else if (hold_done) begin
          state_nxt = ST_HELD;
        end
      end
      ST_HELD: begin
        if (!pressed) begin
          state_nxt = ST_UP;
        end
      end
      ST_RELEASED: state_nxt = ST_UP;
      default:     state_nxt = ST_UP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_UP;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_time_r <= '0;
    end else if (accept) begin
      press_time_r <= press_time_nxt;
    end
  end

  assign status.code     = state_code(state_nxt);
  assign status.released = (state_nxt == ST_RELEASED);

endmodule

>>> hw/rtl/bdhd_merge.sv
// Packs lane results into one result word and buffers it in a two-entry skid.
module bdhd_merge import bdhd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bdhd_lane_t        lanes [LANES_MAX],
  output logic              load_ready,
  bdhd_out_if.source        out_if
);

  bdhd_out_t word;
  bdhd_out_t main_r, skid_r;
  logic      main_valid_r, skid_valid_r;
  logic      pop;

  always_comb begin
    word = '0;
    for (int i = 0; i < LANES_MAX; i++) begin
      word.button_states[CODE_W*i +: CODE_W] = lanes[i].code;
      word.released_pulses[i]                = lanes[i].released;
    end
  end

  assign pop        = main_valid_r && out_if.ready;
  assign load_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (load) begin
        if (!main_valid_r || pop) begin
          main_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          main_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (!main_valid_r || pop) begin
        main_r <= word;
      end else begin
        skid_r <= word;
      end
    end else if (pop && skid_valid_r) begin
      main_r <= skid_r;
    end
  end

  assign out_if.valid = main_valid_r;
  assign out_if.data  = main_r;

endmodule

>>> hw/rtl/button_debounce_hold_detector.sv
// Top level: configuration registers, button lanes and result merge.
//
//   channel | dir | word
//   in_if   | in  | pin_levels[7:0] (active low), now_ms[31:0]
//   out_if  | out | button_states[23:0], released_pulses[7:0]
//   cfg_*   | in  | index 0 debounce_ms, index 1 hold_ms, 16-bit data
//
// One poll per clock while in_if.ready is high; all active button lanes update in the accept cycle.
// Result word is registered in the output register, or in the skid entry while that register is occupied.
// Two-entry skid: in_if.ready drops only when both entries hold a word.
// Reset: all buttons up, thresholds 50 ms and 1000 ms, buffers empty.
module button_debounce_hold_detector import bdhd_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bdhd_in_if.sink               in_if,
  bdhd_out_if.source            out_if,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ACTIVE = (NUM_BUTTONS < LANES_MAX) ? NUM_BUTTONS : LANES_MAX;

  logic [THRESH_W-1:0] debounce_ms_r, hold_ms_r;
  logic                accept, load_ready;
  bdhd_lane_t          lanes [LANES_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_MS_RST;
      hold_ms_r     <= HOLD_MS_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_DEBOUNCE_MS) begin
        debounce_ms_r <= cfg_data[THRESH_W-1:0];
      end else if (cfg_index == CFG_HOLD_MS) begin
        hold_ms_r <= cfg_data[THRESH_W-1:0];
      end
    end
  end

  assign in_if.ready = load_ready;
  assign accept      = in_if.valid && load_ready;

  for (genvar i = 0; i < LANES_MAX; i++) begin : g_lane
    if (i < ACTIVE) begin : g_on
      bdhd_lane u_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pressed     (!in_if.data.pin_levels[i]),
        .now_ms      (in_if.data.now_ms),
        .debounce_ms (debounce_ms_r),
        .hold_ms     (hold_ms_r),
        .status      (lanes[i])
      );
    end else begin : g_off
      assign lanes[i] = '0;
    end
  end

  bdhd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .lanes      (lanes),
    .load_ready (load_ready),
    .out_if     (out_if)
  );

endmodule
